### hw/rtl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// shared types, widths and clip-case tables of the triangle plane clipper
// ----------------------------------------------------------------------------
package tpc_pkg;

   localparam int CW     = 32;              // coordinate width, q16.16
   localparam int NW     = 16;              // normal component width, q2.14
   localparam int OW     = 32;              // plane offset width, q16.16
   localparam int COLW   = 24;              // packed colour width
   localparam int FRAC   = 14;              // fraction bits of the normal
   localparam int PW     = NW + CW;         // one normal times coordinate product
   localparam int SW     = PW + 2;          // sum of three products
   localparam int DW     = SW - FRAC + 1;   // signed distance width
   localparam int TB     = 30;              // fraction bits of the edge parameter
   localparam int QD     = 4;               // queue depth
   localparam int QAW    = $clog2(QD);
   localparam int CSR_IW = 2;

   localparam logic signed [NW-1:0] NZ_RESET = NW'(16384);

   localparam logic [2:0] INS_NONE = 3'b000;

   // vertex indices
   localparam logic [1:0] VA = 2'd0;
   localparam logic [1:0] VB = 2'd1;
   localparam logic [1:0] VC = 2'd2;

   typedef enum logic [CSR_IW-1:0] {
      CSR_NORMAL_X     = 2'd0,
      CSR_NORMAL_Y     = 2'd1,
      CSR_NORMAL_Z     = 2'd2,
      CSR_PLANE_OFFSET = 2'd3
   } csr_idx_type;

   typedef logic signed [CW-1:0] coord_type;
   typedef coord_type [2:0] vert_type;       // [0] x, [1] y, [2] z
   typedef logic signed [DW-1:0] dist_type;

   typedef struct packed {
      logic signed [NW-1:0] nx;
      logic signed [NW-1:0] ny;
      logic signed [NW-1:0] nz;
      logic signed [OW-1:0] offset;
   } plane_type;

   typedef struct packed {
      vert_type [2:0]   v;
      dist_type [2:0]   d;
      logic [2:0]       ins;
      logic [COLW-1:0]  colour;
   } entry_type;

   typedef enum logic [2:0] {
      SEL_V0 = 3'd0,
      SEL_V1 = 3'd1,
      SEL_V2 = 3'd2,
      SEL_N1 = 3'd3,
      SEL_N2 = 3'd4
   } vsel_type;

   typedef struct packed {
      vsel_type a;
      vsel_type b;
      vsel_type c;
   } tri_sel_type;

   typedef struct packed {
      logic [1:0] s;    // inside vertex
      logic [1:0] e;    // outside vertex
   } edge_type;

   // end points of the two cut edges for an inside pattern
   function automatic edge_type edge_ends(input logic [2:0] ins, input logic k);
      edge_type r;
      r.s = VA;
      r.e = VB;
      case (ins)
         3'b001: begin r.s = VA; r.e = k ? VC : VB; end
         3'b010: begin r.s = VB; r.e = k ? VC : VA; end
         3'b100: begin r.s = VC; r.e = k ? VB : VA; end
         3'b011: begin r.s = k ? VB : VA; r.e = VC; end
         3'b101: begin r.s = k ? VC : VA; r.e = VB; end
         3'b110: begin r.s = k ? VC : VB; r.e = VA; end
         default: begin r.s = VA; r.e = VB; end
      endcase
      return r;
   endfunction

   function automatic logic two_pieces(input logic [2:0] ins);
      return (ins inside {3'b011, 3'b101, 3'b110});
   endfunction

   // vertex order of each result triangle, winding kept
   function automatic tri_sel_type tri_plan(input logic [2:0] ins, input logic piece);
      tri_sel_type r;
      r = '{SEL_V0, SEL_V1, SEL_V2};
      case (ins)
         3'b001: r = '{SEL_V0, SEL_N1, SEL_N2};
         3'b010: r = '{SEL_N1, SEL_V1, SEL_N2};
         3'b100: r = '{SEL_N1, SEL_N2, SEL_V2};
         3'b011: r = piece ? tri_sel_type'{SEL_N1, SEL_V1, SEL_N2}
                           : tri_sel_type'{SEL_V0, SEL_V1, SEL_N1};
         3'b101: r = piece ? tri_sel_type'{SEL_N1, SEL_N2, SEL_V2}
                           : tri_sel_type'{SEL_V0, SEL_N1, SEL_V2};
         3'b110: r = piece ? tri_sel_type'{SEL_N1, SEL_V2, SEL_N2}
                           : tri_sel_type'{SEL_N1, SEL_V1, SEL_V2};
         default: r = '{SEL_V0, SEL_V1, SEL_V2};
      endcase
      return r;
   endfunction

endpackage

### hw/rtl/tpc_channels.sv
// ----------------------------------------------------------------------------
// tpc channels
// request and response channels of the triangle plane clipper
// ----------------------------------------------------------------------------
interface tpc_req_if;
   import tpc_pkg::*;
   logic valid;
   logic ready;
   logic signed [CW-1:0] a_x, a_y, a_z;
   logic signed [CW-1:0] b_x, b_y, b_z;
   logic signed [CW-1:0] c_x, c_y, c_z;
   logic [COLW-1:0] tri_colour;

   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   tri_colour, input ready);
   modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   tri_colour, output ready);
endinterface

interface tpc_rsp_if;
   import tpc_pkg::*;
   logic valid;
   logic ready;
   logic signed [CW-1:0] out_a_x, out_a_y, out_a_z;
   logic signed [CW-1:0] out_b_x, out_b_y, out_b_z;
   logic signed [CW-1:0] out_c_x, out_c_y, out_c_z;
   logic [COLW-1:0] out_colour;
   logic last_piece;

   modport source (output valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
                   out_c_x, out_c_y, out_c_z, out_colour, last_piece, input ready);
   modport sink   (input valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
                   out_c_x, out_c_y, out_c_z, out_colour, last_piece, output ready);
endinterface

### hw/rtl/tpc_front.sv
// ----------------------------------------------------------------------------
// tpc_front
// plane distance of the three vertices and inside classification
// ----------------------------------------------------------------------------
module tpc_front (
   input  logic                clock,
   input  logic                reset,
   input  tpc_pkg::plane_type  plane,
   tpc_req_if.sink             req,
   input  logic                q_full,
   output logic                push_valid,
   output tpc_pkg::entry_type  push_entry
);
   import tpc_pkg::*;

   logic                  f_adv;
   logic                  s1_valid_ff;
   vert_type [2:0]        s1_v_ff;
   vert_type [2:0]        s1_v_in;
   logic [COLW-1:0]       s1_col_ff;
   logic signed [PW-1:0]  s1_prod_ff [3][3];
   logic signed [PW-1:0]  s1_prod_in [3][3];
   logic signed [NW-1:0]  nrm [3];
   logic                  s2_valid_ff;
   entry_type             s2_ff;
   entry_type             s2_in;
   logic signed [SW-1:0]  sum [3];

   assign nrm[0] = plane.nx;
   assign nrm[1] = plane.ny;
   assign nrm[2] = plane.nz;

   always_comb begin
      s1_v_in[0][0] = req.a_x;
      s1_v_in[0][1] = req.a_y;
      s1_v_in[0][2] = req.a_z;
      s1_v_in[1][0] = req.b_x;
      s1_v_in[1][1] = req.b_y;
      s1_v_in[1][2] = req.b_z;
      s1_v_in[2][0] = req.c_x;
      s1_v_in[2][1] = req.c_y;
      s1_v_in[2][2] = req.c_z;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s1_prod_in[i][j] = PW'(nrm[j]) * PW'($signed(s1_v_in[i][j]));
         end
      end
   end

   // floor of the exact sum, then the offset
   always_comb begin
      s2_in        = '0;
      s2_in.v      = s1_v_ff;
      s2_in.colour = s1_col_ff;
      for (int i = 0; i < 3; i++) begin
         sum[i] = SW'(s1_prod_ff[i][0]) + SW'(s1_prod_ff[i][1]) + SW'(s1_prod_ff[i][2]);
         s2_in.d[i]   = DW'(sum[i] >>> FRAC) - DW'(plane.offset);
         s2_in.ins[i] = ~s2_in.d[i][DW-1];
      end
   end

   assign f_adv      = !(s2_valid_ff && (s2_ff.ins != INS_NONE) && q_full);
   assign req.ready  = f_adv;
   assign push_valid = s2_valid_ff && (s2_ff.ins != INS_NONE) && !q_full;
   assign push_entry = s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (f_adv) begin
         s1_valid_ff <= req.valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f_adv) begin
         s1_v_ff    <= s1_v_in;
         s1_col_ff  <= req.tri_colour;
         s1_prod_ff <= s1_prod_in;
         s2_ff      <= s2_in;
      end
   end

endmodule

### hw/rtl/tpc_fifo.sv
// ----------------------------------------------------------------------------
// tpc_fifo
// short queue of classified triangles between front and back
// ----------------------------------------------------------------------------
module tpc_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tpc_pkg::entry_type  wdata,
   input  logic                pop,
   output logic                full,
   output logic                rvalid,
   output tpc_pkg::entry_type  rdata
);
   import tpc_pkg::*;

   entry_type       mem [QD];
   logic [QAW-1:0]  wr_ptr_ff;
   logic [QAW-1:0]  rd_ptr_ff;
   logic [QAW:0]    count_ff;
   logic [QAW:0]    count_in;

   assign full     = (count_ff == (QAW+1)'(QD));
   assign rvalid   = (count_ff != '0);
   assign rdata    = mem[rd_ptr_ff];
   assign count_in = count_ff + (QAW+1)'(push) - (QAW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= wdata;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> rvalid)
      else $error("queue pop while empty");

endmodule

### hw/rtl/tpc_back.sv
// ----------------------------------------------------------------------------
// tpc_back
// edge division, interpolation and emission of the result triangles
// ----------------------------------------------------------------------------
module tpc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  tpc_pkg::entry_type  q_entry,
   output logic                q_pop,
   tpc_rsp_if.source           rsp
);
   import tpc_pkg::*;

   typedef struct packed {
      vert_type [2:0]           v;
      logic [2:0]               ins;
      logic [COLW-1:0]          colour;
      logic [1:0][DW:0]         rem;
      logic [1:0][DW:0]         den;
      logic [1:0][TB-1:0]       t;
      logic [1:0][2:0]          neg;
      logic [1:0][2:0][CW-1:0]  mag;
   } div_type;

   typedef struct packed {
      vert_type [2:0]              v;
      logic [2:0]                  ins;
      logic [COLW-1:0]             colour;
      logic [1:0][2:0]             neg;
      logic [1:0][2:0][CW+TB-1:0]  prod;
   } mul_type;

   function automatic vert_type pick(input vsel_type s, input vert_type [2:0] v,
                                     input vert_type [1:0] n);
      vert_type r;
      case (s)
         SEL_V0:  r = v[0];
         SEL_V1:  r = v[1];
         SEL_V2:  r = v[2];
         SEL_N1:  r = n[0];
         SEL_N2:  r = n[1];
         default: r = v[0];
      endcase
      return r;
   endfunction

   logic             b_adv;
   div_type          ld_in;
   div_type          st_in [1:TB];
   div_type          dv_ff [0:TB];
   logic [TB:0]      dv_valid_ff;
   mul_type          mu_in;
   mul_type          mu_ff;
   logic             mu_valid_ff;
   vert_type [1:0]   em_n_in;
   vert_type [1:0]   em_n_ff;
   vert_type [2:0]   em_v_ff;
   logic [2:0]       em_ins_ff;
   logic [COLW-1:0]  em_col_ff;
   logic             em_valid_ff;
   logic             em_piece_ff;
   logic             em_two;
   logic             out_load;
   logic             em_done;
   tri_sel_type      plan;
   vert_type [2:0]   tri_in;
   logic             rsp_valid_ff;
   vert_type [2:0]   rsp_tri_ff;
   logic [COLW-1:0]  rsp_col_ff;
   logic             rsp_last_ff;

   // load: pick edge ends, numerator, denominator and coordinate deltas
   always_comb begin
      edge_type              ed;
      logic signed [DW-1:0]  di;
      logic signed [DW-1:0]  dout;
      logic signed [CW:0]    diff;
      ld_in        = '0;
      ld_in.v      = q_entry.v;
      ld_in.ins    = q_entry.ins;
      ld_in.colour = q_entry.colour;
      for (int k = 0; k < 2; k++) begin
         ed   = edge_ends(q_entry.ins, k[0]);
         di   = q_entry.d[ed.s];
         dout = q_entry.d[ed.e];
         ld_in.rem[k] = {di[DW-1], di};
         ld_in.den[k] = {di[DW-1], di} - {dout[DW-1], dout};
         for (int c = 0; c < 3; c++) begin
            diff = (CW+1)'($signed(q_entry.v[ed.e][c]))
                 - (CW+1)'($signed(q_entry.v[ed.s][c]));
            ld_in.neg[k][c] = diff[CW];
            ld_in.mag[k][c] = CW'(diff[CW] ? -diff : diff);
         end
      end
   end

   // one restoring division step per stage
   always_comb begin
      logic [DW+1:0] r2;
      for (int j = 1; j <= TB; j++) begin
         st_in[j] = dv_ff[j-1];
         for (int k = 0; k < 2; k++) begin
            r2 = {dv_ff[j-1].rem[k], 1'b0};
            if (r2 >= {1'b0, dv_ff[j-1].den[k]}) begin
               st_in[j].rem[k] = (DW+1)'(r2 - {1'b0, dv_ff[j-1].den[k]});
               st_in[j].t[k]   = {dv_ff[j-1].t[k][TB-2:0], 1'b1};
            end else begin
               st_in[j].rem[k] = r2[DW:0];
               st_in[j].t[k]   = {dv_ff[j-1].t[k][TB-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      mu_in        = '0;
      mu_in.v      = dv_ff[TB].v;
      mu_in.ins    = dv_ff[TB].ins;
      mu_in.colour = dv_ff[TB].colour;
      mu_in.neg    = dv_ff[TB].neg;
      for (int k = 0; k < 2; k++) begin
         for (int c = 0; c < 3; c++) begin
            mu_in.prod[k][c] = (CW+TB)'(dv_ff[TB].mag[k][c]) * (CW+TB)'(dv_ff[TB].t[k]);
         end
      end
   end

   // rounded step along the edge from the inside vertex
   always_comb begin
      edge_type          ed;
      logic [CW+TB-1:0]  rnd;
      logic [CW-1:0]     q;
      for (int k = 0; k < 2; k++) begin
         ed = edge_ends(mu_ff.ins, k[0]);
         for (int c = 0; c < 3; c++) begin
            rnd = mu_ff.prod[k][c] + ((CW+TB)'(1) << (TB-1));
            q   = CW'(rnd >> TB);
            em_n_in[k][c] = mu_ff.v[ed.s][c] + (mu_ff.neg[k][c] ? -q : q);
         end
      end
   end

   assign em_two   = two_pieces(em_ins_ff);
   assign out_load = em_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign em_done  = out_load && (!em_two || em_piece_ff);
   assign b_adv    = !em_valid_ff || em_done;
   assign q_pop    = b_adv && q_valid;

   assign plan      = tri_plan(em_ins_ff, em_piece_ff);
   assign tri_in[0] = pick(plan.a, em_v_ff, em_n_ff);
   assign tri_in[1] = pick(plan.b, em_v_ff, em_n_ff);
   assign tri_in[2] = pick(plan.c, em_v_ff, em_n_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff  <= '0;
         mu_valid_ff  <= 1'b0;
         em_valid_ff  <= 1'b0;
         em_piece_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (b_adv) begin
            dv_valid_ff <= {dv_valid_ff[TB-1:0], q_valid};
            mu_valid_ff <= dv_valid_ff[TB];
            em_valid_ff <= mu_valid_ff;
            em_piece_ff <= 1'b0;
         end else if (out_load) begin
            em_piece_ff <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         dv_ff[0] <= ld_in;
         for (int j = 1; j <= TB; j++) dv_ff[j] <= st_in[j];
         mu_ff     <= mu_in;
         em_v_ff   <= mu_ff.v;
         em_n_ff   <= em_n_in;
         em_ins_ff <= mu_ff.ins;
         em_col_ff <= mu_ff.colour;
      end
      if (out_load) begin
         rsp_tri_ff  <= tri_in;
         rsp_col_ff  <= em_col_ff;
         rsp_last_ff <= !em_two || em_piece_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_a_x    = rsp_tri_ff[0][0];
   assign rsp.out_a_y    = rsp_tri_ff[0][1];
   assign rsp.out_a_z    = rsp_tri_ff[0][2];
   assign rsp.out_b_x    = rsp_tri_ff[1][0];
   assign rsp.out_b_y    = rsp_tri_ff[1][1];
   assign rsp.out_b_z    = rsp_tri_ff[1][2];
   assign rsp.out_c_x    = rsp_tri_ff[2][0];
   assign rsp.out_c_y    = rsp_tri_ff[2][1];
   assign rsp.out_c_z    = rsp_tri_ff[2][2];
   assign rsp.out_colour = rsp_col_ff;
   assign rsp.last_piece = rsp_last_ff;

   a_single_piece: assert property (@(posedge clock) disable iff (reset)
      em_valid_ff && !em_two |-> !em_piece_ff)
      else $error("second piece on a one-triangle clip");
   a_no_empty_clip: assert property (@(posedge clock) disable iff (reset)
      em_valid_ff |-> em_ins_ff != INS_NONE)
      else $error("fully clipped triangle reached the emitter");
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      out_load && !em_done |=> em_valid_ff && em_piece_ff)
      else $error("first of two pieces sent without the second pending");

endmodule

### hw/rtl/triangle_plane_clipper.sv
// ----------------------------------------------------------------------------
// triangle_plane_clipper
// single-plane triangle clipper with csr-held plane and two-stage decoupling
// ----------------------------------------------------------------------------
// A request carries one triangle (three q16.16 vertices) and a colour; the
// plane is the csr-held q2.14 normal and q16.16 offset. A vertex whose
// distance is zero or more is inside. All inside gives the triangle back,
// one or two inside give one or two clipped triangles in the input winding,
// none inside gives no response. last_piece marks the final response of a
// request. A request is accepted every cycle while the queue has room; the
// response port sends one triangle per cycle while rsp.ready is high, and a
// request yielding two triangles stalls the back end until both are sent.
// The path runs through two front stages (products, then distance and
// classification), the queue, a load stage, a 30-stage pipelined restoring
// divider (one per cut edge, two side by side), a multiply stage, the
// interpolation/emit register and the output register.
// Write the csr only while no request is in flight.
// ----------------------------------------------------------------------------
module triangle_plane_clipper (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tpc_pkg::CSR_IW-1:0]      csr_index,
   input  logic [tpc_pkg::OW-1:0]          csr_wdata,
   tpc_req_if.sink                         req_ch,
   tpc_rsp_if.source                       rsp_ch
);
   import tpc_pkg::*;

   plane_type  plane_ff;
   plane_type  plane_in;
   logic       q_full;
   logic       push_valid;
   entry_type  push_entry;
   logic       q_valid;
   entry_type  q_entry;
   logic       q_pop;

   // csr write decode
   always_comb begin
      plane_in = plane_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_NORMAL_X:     plane_in.nx     = NW'(csr_wdata);
            CSR_NORMAL_Y:     plane_in.ny     = NW'(csr_wdata);
            CSR_NORMAL_Z:     plane_in.nz     = NW'(csr_wdata);
            CSR_PLANE_OFFSET: plane_in.offset = csr_wdata;
            default:          plane_in        = plane_ff;
         endcase
      end
   end

   // plane defaults to z = 0 facing +z
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff.nx     <= '0;
         plane_ff.ny     <= '0;
         plane_ff.nz     <= NZ_RESET;
         plane_ff.offset <= '0;
      end else begin
         plane_ff <= plane_in;
      end
   end

   // front: distance and inside pattern, drops fully clipped triangles
   tpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .plane      (plane_ff),
      .req        (req_ch),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // queue so the front keeps accepting while the back emits two pieces
   tpc_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push_valid),
      .wdata  (push_entry),
      .pop    (q_pop),
      .full   (q_full),
      .rvalid (q_valid),
      .rdata  (q_entry)
   );

   // back: edge division, interpolation, result emission
   tpc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule
